[src/apa102_frame_builder_top_macros.svh]
// Assertion macros for the frame builder checker
`ifndef APA102_FRAME_BUILDER_TOP_MACROS_SVH
`define APA102_FRAME_BUILDER_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define AFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define AFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/afb_pkg.sv]
// Types and constants for the LED frame builder
package afb_pkg;

   typedef enum logic [2:0] {
      FUNC_SET_BRIGHT = 3'd0,
      FUNC_SET_COLOR  = 3'd1,
      FUNC_CLEAR      = 3'd2,
      FUNC_RESET      = 3'd3,
      FUNC_EMIT       = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_HEAD,
      ST_LED,
      ST_TAIL
   } state_type;

   typedef enum logic [1:0] {
      WSEL_NONE,
      WSEL_START,
      WSEL_LED,
      WSEL_END
   } wsel_type;

   typedef struct packed {
      logic     strobe;
      logic     status;
      wsel_type wsel;
      logic     last;
   } rsp_ctl_type;

   typedef struct packed {
      logic bri;
      logic col;
   } mem_we_type;

   localparam logic       STATUS_OK    = 1'b0;
   localparam logic       STATUS_RANGE = 1'b1;
   localparam logic [2:0] FRAME_HEAD   = 3'b111;
   localparam logic [31:0] START_WORD  = 32'h0000_0000;
   localparam logic [31:0] END_WORD    = 32'hFFFF_FFFF;
   localparam int         BRI_W        = 5;
   localparam int         COL_W        = 24;

endpackage

[src/apa102_frame_builder_top.sv]
// Top level of the LED frame builder: stores, sequencer and word formatter
// Commands are taken one at a time while busy is low. Set brightness, set
// color, clear colors, reset all and unused codes give one result in the
// cycle after start. Emit gives LED_COUNT + 2 results on consecutive cycles,
// starting the cycle after start (start word, one word per LED, end word
// with last); the walk reads one LED entry per cycle through the single read
// port of each store. Results are not held: every strobe cycle carries one
// result that must be taken then. After reset the valid bits make every
// entry read as zero at once; no clearing pass is needed.
module apa102_frame_builder_top import afb_pkg::*; #(
   parameter int LED_COUNT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_led_index,
   input  logic [4:0]  req_brightness,
   input  logic [23:0] req_color,
   output logic        rsp_strobe,
   output logic        rsp_status,
   output logic [31:0] rsp_frame_word,
   output logic        rsp_is_frame_word,
   output logic        rsp_last
);

   localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   mem_we_type       mem_we;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic             bri_ok;
   logic             col_ok;
   rsp_ctl_type      rsp_ctl;
   logic [BRI_W-1:0] bri_rd;
   logic [COL_W-1:0] col_rd;
   logic [BRI_W-1:0] bri_val;
   logic [COL_W-1:0] col_val;

   afb_seq #(.LED_COUNT(LED_COUNT)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_led_index (req_led_index),
      .mem_we        (mem_we),
      .wr_addr       (wr_addr),
      .rd_addr       (rd_addr),
      .bri_ok        (bri_ok),
      .col_ok        (col_ok),
      .rsp_ctl       (rsp_ctl)
   );

   afb_ram #(.WIDTH(BRI_W), .DEPTH(LED_COUNT)) u_bri_ram (
      .clock   (clock),
      .wr_en   (mem_we.bri),
      .wr_addr (wr_addr),
      .wr_data (req_brightness),
      .rd_addr (rd_addr),
      .rd_data (bri_rd)
   );

   afb_ram #(.WIDTH(COL_W), .DEPTH(LED_COUNT)) u_col_ram (
      .clock   (clock),
      .wr_en   (mem_we.col),
      .wr_addr (wr_addr),
      .wr_data (req_color),
      .rd_addr (rd_addr),
      .rd_data (col_rd)
   );

   assign bri_val = bri_ok ? bri_rd : '0;
   assign col_val = col_ok ? col_rd : '0;

   always_comb begin
      unique case (rsp_ctl.wsel)
         WSEL_NONE:  rsp_frame_word = '0;
         WSEL_START: rsp_frame_word = START_WORD;
         WSEL_LED:   rsp_frame_word = {FRAME_HEAD, bri_val, col_val[7:0],
                                       col_val[15:8], col_val[23:16]};
         WSEL_END:   rsp_frame_word = END_WORD;
         default:    rsp_frame_word = '0;
      endcase
   end

   assign rsp_strobe        = rsp_ctl.strobe;
   assign rsp_status        = rsp_ctl.status;
   assign rsp_is_frame_word = rsp_ctl.wsel != WSEL_NONE;
   assign rsp_last          = rsp_ctl.last;

endmodule

[src/afb_ram.sv]
// Generic single-port-write, registered-read RAM
module afb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/afb_seq.sv]
// Command sequencer: store valid bits, emit walk and response control
module afb_seq import afb_pkg::*; #(
   parameter int LED_COUNT = 12,
   localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_func,
   input  logic [7:0]       req_led_index,
   output mem_we_type       mem_we,
   output logic [IDX_W-1:0] wr_addr,
   output logic [IDX_W-1:0] rd_addr,
   output logic             bri_ok,
   output logic             col_ok,
   output rsp_ctl_type      rsp_ctl
);

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 status_ff, status_in;
   logic [LED_COUNT-1:0] bri_vld_ff, bri_vld_in;
   logic [LED_COUNT-1:0] col_vld_ff, col_vld_in;
   logic                 bri_ok_ff, col_ok_ff;
   logic                 in_range;
   logic                 cnt_last;

   assign in_range = req_led_index < 8'(LED_COUNT);
   assign wr_addr  = req_led_index[IDX_W-1:0];
   assign cnt_last = cnt_ff == IDX_W'(LED_COUNT - 1);
   assign busy     = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bri_vld_ff <= '0;
         col_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bri_vld_ff <= bri_vld_in;
         col_vld_ff <= col_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      bri_ok_ff <= bri_vld_ff[rd_addr];
      col_ok_ff <= col_vld_ff[rd_addr];
   end

   assign bri_ok = bri_ok_ff;
   assign col_ok = col_ok_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      status_in   = status_ff;
      bri_vld_in  = bri_vld_ff;
      col_vld_in  = col_vld_ff;
      mem_we      = '0;
      rd_addr     = '0;
      rsp_ctl     = '{strobe: 1'b0, status: STATUS_OK, wsel: WSEL_NONE, last: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in  = ST_ACK;
               status_in = STATUS_OK;
               unique case (func_type'(req_func))
                  FUNC_SET_BRIGHT: begin
                     if (in_range) begin
                        mem_we.bri          = 1'b1;
                        bri_vld_in[wr_addr] = 1'b1;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  FUNC_SET_COLOR: begin
                     if (in_range) begin
                        mem_we.col          = 1'b1;
                        col_vld_in[wr_addr] = 1'b1;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  FUNC_CLEAR: begin
                     col_vld_in = '0;
                  end
                  FUNC_RESET: begin
                     bri_vld_in = '0;
                     col_vld_in = '0;
                  end
                  FUNC_EMIT: begin
                     state_in = ST_HEAD;
                     cnt_in   = '0;
                  end
                  default: begin
                     state_in = ST_ACK;
                  end
               endcase
            end
         end
         ST_ACK: begin
            rsp_ctl  = '{strobe: 1'b1, status: status_ff, wsel: WSEL_NONE, last: 1'b1};
            state_in = ST_IDLE;
         end
         ST_HEAD: begin
            rsp_ctl  = '{strobe: 1'b1, status: STATUS_OK, wsel: WSEL_START, last: 1'b0};
            rd_addr  = '0;
            state_in = ST_LED;
         end
         ST_LED: begin
            rsp_ctl = '{strobe: 1'b1, status: STATUS_OK, wsel: WSEL_LED, last: 1'b0};
            if (cnt_last) begin
               rd_addr  = '0;
               state_in = ST_TAIL;
            end else begin
               rd_addr = cnt_ff + 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         ST_TAIL: begin
            rsp_ctl  = '{strobe: 1'b1, status: STATUS_OK, wsel: WSEL_END, last: 1'b1};
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/afb_checker.sv]
// Port-level checker for the LED frame builder, bound to the top level
`include "apa102_frame_builder_top_macros.svh"

module afb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_status,
   input logic        rsp_is_frame_word,
   input logic        rsp_last
);

   `AFB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "not busy after accept")
   `AFB_ASSERT_NOW(a_beat_busy, clock, reset, rsp_strobe, busy, "beat while idle")
   `AFB_ASSERT_NEXT(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy, "busy after last")
   `AFB_ASSERT_NOW(a_err_single, clock, reset, rsp_strobe && rsp_status, rsp_last && !rsp_is_frame_word, "error beat not single")

endmodule

bind apa102_frame_builder_top afb_checker u_afb_checker (.*);
